// ===== rtl/core/wildcard_byte_pattern_scan_macros.svh =====
// ----------------------------------------------------------------------------
// Wildcard byte pattern scan assertion macros
// Concurrent assertion shorthands clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_BYTE_PATTERN_SCAN_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SCAN_MACROS_SVH

// same-cycle implication
`define WBPS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WBPS_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/wbps_pkg.sv =====
// ----------------------------------------------------------------------------
// Wildcard byte pattern scan package
// Shared widths, register indexes and word types of the scan block.
// ----------------------------------------------------------------------------
package wbps_pkg;

   localparam int PATTERN_MAX_DEFAULT   = 64;
   localparam int ADDRESS_WIDTH_DEFAULT = 24;

   localparam int INDEX_W  = 6;
   localparam int BYTE_W   = 8;
   localparam int POS_W    = 24;
   localparam int PLEN_W   = 7;
   localparam int LIMIT_W  = 25;
   localparam int COUNT_W  = 25;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 25;
   localparam int SUM_W    = 33;

   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_SCAN_LIMIT     = 1'b1;

   localparam logic [PLEN_W-1:0]  PLEN_RESET = 7'd1;
   localparam logic [LIMIT_W-1:0] NO_LIMIT   = 25'h1FF_FFFF;

   typedef struct packed {
      logic                 shift;
      logic                 write;
      logic [BYTE_W-1:0]    data;
      logic [INDEX_W-1:0]   pat_index;
      logic [BYTE_W-1:0]    pat_value;
      logic                 pat_wild;
   } cell_ctl_type;

   typedef struct packed {
      logic                 found;
      logic [POS_W-1:0]     match_position;
   } rsp_word_type;

endpackage

// ===== rtl/core/wbps_req_if.sv =====
// ----------------------------------------------------------------------------
// Wildcard byte pattern scan request channel
// Valid/ready channel carrying pattern writes and data bytes.
// ----------------------------------------------------------------------------
interface wbps_req_if;
   logic                          valid;
   logic                          ready;
   logic                          func;
   logic [wbps_pkg::INDEX_W-1:0]  pattern_index;
   logic [wbps_pkg::BYTE_W-1:0]   pattern_value;
   logic                          pattern_wildcard;
   logic [wbps_pkg::BYTE_W-1:0]   data_byte;
   logic [wbps_pkg::POS_W-1:0]    base_offset;
   logic                          last_byte;

   modport source (
      output valid, func, pattern_index, pattern_value, pattern_wildcard,
             data_byte, base_offset, last_byte,
      input  ready
   );
   modport sink (
      input  valid, func, pattern_index, pattern_value, pattern_wildcard,
             data_byte, base_offset, last_byte,
      output ready
   );
endinterface

// ===== rtl/core/wbps_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Wildcard byte pattern scan response channel
// Valid/ready channel carrying one search result word.
// ----------------------------------------------------------------------------
interface wbps_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        found;
   logic [wbps_pkg::POS_W-1:0]  match_position;

   modport source (output valid, found, match_position, input ready);
   modport sink   (input  valid, found, match_position, output ready);
endinterface

// ===== rtl/core/wbps_csr_if.sv =====
// ----------------------------------------------------------------------------
// Wildcard byte pattern scan register write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface wbps_csr_if;
   logic                             valid;
   logic                             ready;
   logic [wbps_pkg::CSR_IDX_W-1:0]   index;
   logic [wbps_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input  valid, index, data, output ready);
endinterface

// ===== rtl/core/wbps_cell.sv =====
// ----------------------------------------------------------------------------
// Wildcard byte pattern scan cell
// Holds one pattern entry and the partial match flag of the prefix ending here.
// ----------------------------------------------------------------------------
module wbps_cell #(
   parameter int INDEX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  wbps_pkg::cell_ctl_type ctl,
   input  logic                   prev_hit,
   output logic                   hit_in,
   output logic                   hit_ff
);

   logic [wbps_pkg::BYTE_W-1:0] pat_ff;
   logic                        wild_ff;
   logic                        sel;

   assign sel    = ctl.write && (32'(ctl.pat_index) == INDEX);
   assign hit_in = prev_hit && (wild_ff || (pat_ff == ctl.data));

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (ctl.shift) begin
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sel) begin
         pat_ff  <= ctl.pat_value;
         wild_ff <= ctl.pat_wild;
      end
   end

endmodule

// ===== rtl/core/wbps_out_buf.sv =====
// ----------------------------------------------------------------------------
// Wildcard byte pattern scan output buffer
// Two-entry result queue between the matcher and the response channel.
// ----------------------------------------------------------------------------
module wbps_out_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  wbps_pkg::rsp_word_type push_word,
   input  logic                   pop,
   output logic                   head_valid,
   output wbps_pkg::rsp_word_type head_word,
   output logic                   full
);

   logic [1:0]             cnt_ff, cnt_in;
   wbps_pkg::rsp_word_type slot0_ff, slot0_in;
   wbps_pkg::rsp_word_type slot1_ff, slot1_in;

   assign head_valid = (cnt_ff != 2'd0);
   assign head_word  = slot0_ff;
   assign full       = (cnt_ff == 2'd2);

   always_comb begin
      cnt_in   = cnt_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      case ({push, pop})
         2'b10: begin
            if (cnt_ff == 2'd0) begin
               slot0_in = push_word;
            end else begin
               slot1_in = push_word;
            end
            cnt_in = cnt_ff + 2'd1;
         end
         2'b01: begin
            slot0_in = slot1_ff;
            cnt_in   = cnt_ff - 2'd1;
         end
         2'b11: begin
            if (cnt_ff == 2'd1) begin
               slot0_in = push_word;
            end else begin
               slot0_in = slot1_ff;
               slot1_in = push_word;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

// ===== rtl/core/wildcard_byte_pattern_scan.sv =====
// ----------------------------------------------------------------------------
// Wildcard byte pattern scan
// Systolic search for a byte pattern with wildcard entries in a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   csr_if writes pattern_length (index 0) and scan_limit (index 1); always
//   ready. req_if carries one word per cycle while ready is high: func 0
//   loads a pattern entry, func 1 delivers a data byte, last_byte closes the search.
//   rsp_if returns one word per search: found and match_position, at the first
//   match, past scan_limit, at byte count saturation or at the last byte.
// Dataflow:
//   One request word per cycle while req_if.ready is high. The result of a
//   byte enters the output queue and shows on rsp_if from the queue head.
//   PATTERN_MAX cells extend the partial match flags for each byte in one step.
// Stall:
//   Results wait in a two-entry queue; req_if.ready drops while it is full.
// Reset:
//   Sets pattern_length to 1, scan_limit to unlimited and clears the search
//   state. Pattern entries are undefined until written; no clearing pass.
// ----------------------------------------------------------------------------
`include "wildcard_byte_pattern_scan_macros.svh"

module wildcard_byte_pattern_scan #(
   parameter int PATTERN_MAX   = wbps_pkg::PATTERN_MAX_DEFAULT,
   parameter int ADDRESS_WIDTH = wbps_pkg::ADDRESS_WIDTH_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   wbps_req_if.sink   req_if,
   wbps_rsp_if.source rsp_if,
   wbps_csr_if.sink   csr_if
);

   localparam int CELL_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
   localparam logic [wbps_pkg::SUM_W-1:0] ADDR_MASK =
      (wbps_pkg::SUM_W'(1) << ADDRESS_WIDTH) - wbps_pkg::SUM_W'(1);

   logic [wbps_pkg::PLEN_W-1:0]  plen_ff;
   logic [wbps_pkg::LIMIT_W-1:0] limit_ff;
   logic [wbps_pkg::COUNT_W-1:0] seen_ff, seen_in;
   logic [wbps_pkg::POS_W-1:0]   start_ff, start_in;
   logic                         done_ff, done_in;

   logic                         acc, acc_pat, acc_data, live, full, seen_max;
   logic                         window_full, over_limit, match_now, hit, emit;
   logic [LEN_W-1:0]             len_eff;
   logic [CELL_W-1:0]            sel;
   logic [wbps_pkg::COUNT_W-1:0] n, s;
   logic [wbps_pkg::POS_W-1:0]   start_eff;
   logic [wbps_pkg::SUM_W-1:0]   pos_full;
   logic [PATTERN_MAX-1:0]       hit_in, hit_ff;
   wbps_pkg::cell_ctl_type       ctl;
   wbps_pkg::rsp_word_type       res, head;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff  <= wbps_pkg::PLEN_RESET;
         limit_ff <= wbps_pkg::NO_LIMIT;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            wbps_pkg::REG_PATTERN_LENGTH: plen_ff  <= csr_if.data[wbps_pkg::PLEN_W-1:0];
            wbps_pkg::REG_SCAN_LIMIT:     limit_ff <= csr_if.data[wbps_pkg::LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign acc      = req_if.valid && req_if.ready;
   assign acc_pat  = acc && !req_if.func;
   assign acc_data = acc && req_if.func;
   assign live     = acc_data && !done_ff;
   assign req_if.ready = !full;

   always_comb begin
      if (plen_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (32'(plen_ff) > PATTERN_MAX) begin
         len_eff = LEN_W'(PATTERN_MAX);
      end else begin
         len_eff = LEN_W'(plen_ff);
      end
   end

   assign sel = CELL_W'(len_eff - LEN_W'(1));

   assign ctl.shift     = live;
   assign ctl.write     = acc_pat && (seen_ff == '0) && !done_ff;
   assign ctl.data      = req_if.data_byte;
   assign ctl.pat_index = req_if.pattern_index;
   assign ctl.pat_value = req_if.pattern_value;
   assign ctl.pat_wild  = req_if.pattern_wildcard;

   for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
      logic prev_hit;
      if (g == 0) begin : g_head
         assign prev_hit = 1'b1;
      end else begin : g_link
         assign prev_hit = hit_ff[g-1];
      end
      wbps_cell #(.INDEX(g)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .prev_hit (prev_hit),
         .hit_in   (hit_in[g]),
         .hit_ff   (hit_ff[g])
      );
   end

   assign match_now   = hit_in[sel];
   assign seen_max    = &seen_ff;
   assign n           = seen_ff + wbps_pkg::COUNT_W'(1);
   assign s           = n - wbps_pkg::COUNT_W'(len_eff);
   assign window_full = ({1'b0, n} >= (wbps_pkg::COUNT_W + 1)'(len_eff));
   assign over_limit  = (limit_ff != wbps_pkg::NO_LIMIT) &&
                        ($signed({1'b0, s}) > $signed({limit_ff[wbps_pkg::LIMIT_W-1], limit_ff}));
   assign start_eff   = (seen_ff == '0) ? req_if.base_offset : start_ff;
   assign pos_full    = (wbps_pkg::SUM_W'(start_eff) + wbps_pkg::SUM_W'(s)) & ADDR_MASK;

   assign hit  = live && !seen_max && window_full && !over_limit && match_now;
   assign emit = live && (seen_max || req_if.last_byte ||
                          (window_full && (over_limit || match_now)));

   assign res.found          = hit;
   assign res.match_position = hit ? pos_full[wbps_pkg::POS_W-1:0] : '0;

   always_comb begin
      seen_in  = seen_ff;
      done_in  = done_ff;
      start_in = start_ff;
      if (live && (seen_ff == '0)) begin
         start_in = req_if.base_offset;
      end
      if (live && !seen_max) begin
         seen_in = n;
      end
      if (emit) begin
         done_in = 1'b1;
      end
      if (acc_data && req_if.last_byte) begin
         seen_in = '0;
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= '0;
         start_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         seen_ff  <= seen_in;
         start_ff <= start_in;
         done_ff  <= done_in;
      end
   end

   wbps_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (emit),
      .push_word  (res),
      .pop        (rsp_if.valid && rsp_if.ready),
      .head_valid (rsp_if.valid),
      .head_word  (head),
      .full       (full)
   );

   assign rsp_if.found          = head.found;
   assign rsp_if.match_position = head.match_position;

   `WBPS_ASSERT_IMP(a_push_on_data, emit, acc_data && !done_ff, "result without live data byte")
   `WBPS_ASSERT_IMP(a_miss_zero_pos, emit && !res.found, res.match_position == '0, "miss with nonzero position")
   `WBPS_ASSERT_NXT(a_last_clears, acc_data && req_if.last_byte, !done_ff && (seen_ff == '0), "search not closed by last byte")

endmodule
